// ===== sv/blv_pkg.sv =====
// Shared constants, the voltage/charge table and derived widths for the battery level unit.
package blv_pkg;

  localparam int ADC_W      = 12;
  localparam int GAIN_W     = 13;
  localparam int THR_W      = 16;
  localparam int OFS_W      = 8;
  localparam int PCT_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN = 2'd0,
    REG_THR  = 2'd1,
    REG_OFS  = 2'd2
  } cfg_reg_t;

  localparam logic [GAIN_W-1:0] GAIN_RST = GAIN_W'(512);
  localparam logic [THR_W-1:0]  THR_RST  = THR_W'(3300);
  localparam logic [OFS_W-1:0]  OFS_RST  = OFS_W'(30);

  localparam int FRAC_BITS = 8;
  localparam int PROD_W    = ADC_W + GAIN_W;
  localparam int VSC_W     = PROD_W - FRAC_BITS;
  localparam int VB_W      = VSC_W + 1;

  localparam int TABLE_SIZE = 12;
  localparam int NUM_POINTS = 12;
  localparam int NP = (NUM_POINTS > TABLE_SIZE) ? TABLE_SIZE :
                      ((NUM_POINTS < 2) ? 2 : NUM_POINTS);
  localparam int SEG_W = (NP > 2) ? $clog2(NP) : 1;

  localparam int MV_W = 13;
  localparam logic [MV_W-1:0] OCV_MV [TABLE_SIZE] = '{
    13'd4200, 13'd4060, 13'd3980, 13'd3920, 13'd3870, 13'd3820,
    13'd3790, 13'd3770, 13'd3740, 13'd3680, 13'd3450, 13'd3000
  };
  localparam logic [PCT_W-1:0] OCV_PCT [TABLE_SIZE] = '{
    7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50,
    7'd40,  7'd30, 7'd20, 7'd10, 7'd5,  7'd0
  };
  localparam logic [PCT_W-1:0] PCT_FULL  = PCT_W'(100);
  localparam logic [PCT_W-1:0] PCT_EMPTY = PCT_W'(0);

  function automatic int max_den();
    int m;
    m = 1;
    for (int i = 1; i < NP; i++) begin
      if (int'(OCV_MV[i-1]) - int'(OCV_MV[i]) > m) m = int'(OCV_MV[i-1]) - int'(OCV_MV[i]);
    end
    return m;
  endfunction

  function automatic int max_step();
    int m;
    m = 1;
    for (int i = 1; i < NP; i++) begin
      if (int'(OCV_PCT[i-1]) - int'(OCV_PCT[i]) > m) m = int'(OCV_PCT[i-1]) - int'(OCV_PCT[i]);
    end
    return m;
  endfunction

  localparam int MAX_DEN = max_den();
  localparam int QMAX    = max_step();
  localparam int DV_W    = $clog2(MAX_DEN + 1);
  localparam int DP_W    = $clog2(QMAX + 1);
  localparam int NUM_W   = $clog2(MAX_DEN * QMAX + 1);

  // Quotient thresholds: row = segment, column k holds (k+1) * segment width.
  typedef logic [NP-1:0][QMAX-1:0][NUM_W-1:0] th_tab_t;

  function automatic th_tab_t build_th();
    th_tab_t t;
    int den;
    t = '0;
    for (int s = 1; s < NP; s++) begin
      den = int'(OCV_MV[s-1]) - int'(OCV_MV[s]);
      for (int k = 0; k < QMAX; k++) begin
        // a flat segment is never selected; keep its thresholds out of reach
        t[s][k] = (den == 0) ? '1 : NUM_W'((k + 1) * den);
      end
    end
    return t;
  endfunction

  localparam th_tab_t TH = build_th();

endpackage

// ===== sv/blv_if.sv =====
// Channel interfaces: ADC samples in, charge levels out, register writes.
interface blv_in_if;
  logic                      valid;
  logic                      ready;
  logic [blv_pkg::ADC_W-1:0] adc_mv;
  modport source (output valid, output adc_mv, input ready);
  modport sink   (input valid, input adc_mv, output ready);
endinterface

interface blv_out_if;
  logic                      valid;
  logic                      ready;
  logic [blv_pkg::PCT_W-1:0] charge_percent;
  modport source (output valid, output charge_percent, input ready);
  modport sink   (input valid, input charge_percent, output ready);
endinterface

interface blv_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [blv_pkg::CFG_IDX_W-1:0]  index;
  logic [blv_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/battery_level_from_voltage_unit.sv =====
// Battery charge level from ADC pin voltage: pipelined piecewise linear table lookup.
//
// Channels: samples (sink) carries adc_mv, levels (source) carries charge_percent,
// cfg (sink) writes divider gain (index 0), offset threshold (1) and offset (2).
// cfg is always ready; write it only while the pipeline is empty.
// Every sample gives exactly one level, in order.
// Pipeline: 1 multiply, 2 scale and offset, 3 segment search, 4 numerator
// multiply, 5 quotient count and sum into the output register.
// Five register stages lie between sample transfer and levels.valid, the
// first loaded at the transfer edge; one sample per cycle is accepted while
// levels is taken every cycle.
// The whole pipeline advances together: when levels.valid is high and
// levels.ready low, every stage holds and samples.ready drops, so nothing is
// lost or repeated. Bubbles are not squeezed out during a stall.
// Reset (rst, synchronous) empties the pipeline and loads the register
// defaults: gain x2, threshold 3300 mV, offset 30 mV.
module battery_level_from_voltage_unit (
  input logic clk,
  input logic rst,
  blv_in_if.sink     samples,
  blv_out_if.source  levels,
  blv_cfg_if.sink    cfg
);
  import blv_pkg::*;

  logic [GAIN_W-1:0] divider_gain_q8;
  logic [THR_W-1:0]  offset_threshold_mv;
  logic [OFS_W-1:0]  offset_mv;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      divider_gain_q8     <= GAIN_RST;
      offset_threshold_mv <= THR_RST;
      offset_mv           <= OFS_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_GAIN: divider_gain_q8     <= cfg.data[GAIN_W-1:0];
        REG_THR:  offset_threshold_mv <= cfg.data[THR_W-1:0];
        REG_OFS:  offset_mv           <= cfg.data[OFS_W-1:0];
        default: ;
      endcase
    end
  end

  // stage valids and payload
  logic v1, v2, v3, v4, v5;
  logic en;

  logic [PROD_W-1:0] prod;
  logic [VB_W-1:0]   vbat;
  logic [SEG_W-1:0]  seg3, seg4;
  logic [DV_W-1:0]   dv;
  logic [DP_W-1:0]   dp;
  logic [PCT_W-1:0]  pl3, pl4;
  logic [NUM_W-1:0]  num;
  logic [PCT_W-1:0]  charge;

  assign en            = !v5 || levels.ready;
  assign samples.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= samples.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // stage 2: drop fraction, add offset above threshold
  logic [VSC_W-1:0] vscaled;
  logic [VB_W-1:0]  vbat_next;

  always_comb begin
    vscaled = prod[PROD_W-1:FRAC_BITS];
    if (vscaled > VSC_W'(offset_threshold_mv)) begin
      vbat_next = VB_W'(vscaled) + VB_W'(offset_mv);
    end else begin
      vbat_next = VB_W'(vscaled);
    end
  end

  // stage 3: first table point below vbat; clamped ends go through as dp = 0
  logic             full, empty;
  logic [SEG_W-1:0] seg_next, seg_hi;
  logic [VB_W-1:0]  dv_wide;
  logic [PCT_W-1:0] pl_next, dp_wide;
  logic [DV_W-1:0]  dv_next;
  logic [DP_W-1:0]  dp_next;

  always_comb begin
    full     = vbat >= VB_W'(OCV_MV[0]);
    empty    = vbat <= VB_W'(OCV_MV[NP-1]);
    seg_next = SEG_W'(1);
    for (int i = NP - 1; i >= 1; i--) begin
      if (vbat > VB_W'(OCV_MV[i])) seg_next = SEG_W'(i);
    end
    seg_hi  = seg_next - SEG_W'(1);
    dv_wide = vbat - VB_W'(OCV_MV[seg_next]);
    dp_wide = OCV_PCT[seg_hi] - OCV_PCT[seg_next];
    if (full || empty) begin
      pl_next = full ? PCT_FULL : PCT_EMPTY;
      dv_next = '0;
      dp_next = '0;
    end else begin
      pl_next = OCV_PCT[seg_next];
      dv_next = dv_wide[DV_W-1:0];
      dp_next = dp_wide[DP_W-1:0];
    end
  end

  // stage 5: quotient is at most QMAX, so count threshold hits
  logic [DP_W-1:0] q;

  always_comb begin
    q = '0;
    for (int k = 0; k < QMAX; k++) begin
      if (num >= TH[seg4][k]) q = q + DP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod   <= PROD_W'(samples.adc_mv) * PROD_W'(divider_gain_q8);
      vbat   <= vbat_next;
      seg3   <= seg_next;
      pl3    <= pl_next;
      dv     <= dv_next;
      dp     <= dp_next;
      num    <= NUM_W'(dv) * NUM_W'(dp);
      seg4   <= seg3;
      pl4    <= pl3;
      charge <= pl4 + PCT_W'(q);
    end
  end

  assign levels.valid          = v5;
  assign levels.charge_percent = charge;

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    levels.valid |-> levels.charge_percent <= PCT_FULL)
    else $error("charge level above full");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !v1 && !v2 && !v3 && !v4 && !v5)
    else $error("pipeline not empty after reset");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    levels.valid && !levels.ready |-> !samples.ready)
    else $error("sample taken while output stalled");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    samples.valid && samples.ready |=> v1)
    else $error("transferred sample lost at pipeline entry");

endmodule
